### rtl/espc_pkg.sv
// Shared types and constants for the equal subset partition checker.
`default_nettype none

package espc_pkg;

    // The running total is kept to a fixed width and saturates.
    localparam int SUM_W = 12;
    localparam logic [SUM_W-1:0] SUM_MAX = 12'd4095;

    // Side information registered with each memory read, used to decide
    // what the read word really holds.
    typedef struct packed {
        logic outside;   // Source word lies below the bottom of the bitmap.
        logic fresh;     // Bitmap not yet written since it was last cleared.
        logic zero_word; // Word zero, which holds the always-reachable sum zero.
    } t_rd_tag;

endpackage

`default_nettype wire

### rtl/espc_mem.sv
// Bitmap word memory: one write port, two registered read ports.
`default_nettype none

module espc_mem #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr_a,
    input  wire logic [ADDR_W-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]  o_rdata_a,
    output logic      [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### rtl/espc_merge.sv
// Word update: resolves read words and ORs the shifted source bits into a word.
`default_nettype none

module espc_merge #(
    parameter int WORD_BITS = 64,
    parameter int SH_W      = 6
) (
    input  wire logic [WORD_BITS-1:0] i_dest_raw,
    input  wire espc_pkg::t_rd_tag    i_dest_tag,
    input  wire logic [WORD_BITS-1:0] i_lo_raw,
    input  wire espc_pkg::t_rd_tag    i_lo_tag,
    input  wire logic [WORD_BITS-1:0] i_hi,
    input  wire logic [SH_W-1:0]      i_shift,
    output logic      [WORD_BITS-1:0] o_dest,
    output logic      [WORD_BITS-1:0] o_lo,
    output logic      [WORD_BITS-1:0] o_word
);

    logic [SH_W:0] lo_shift;

    // A word that was never written since the last clear reads as the
    // cleared bitmap: only bit zero of word zero is set.
    always_comb begin
        if (i_dest_tag.outside) begin
            o_dest = '0;
        end else if (i_dest_tag.fresh) begin
            o_dest = WORD_BITS'(i_dest_tag.zero_word);
        end else begin
            o_dest = i_dest_raw;
        end

        if (i_lo_tag.outside) begin
            o_lo = '0;
        end else if (i_lo_tag.fresh) begin
            o_lo = WORD_BITS'(i_lo_tag.zero_word);
        end else begin
            o_lo = i_lo_raw;
        end
    end

    // A shift of zero moves the whole lower word out, leaving nothing.
    assign lo_shift = (SH_W+1)'(WORD_BITS) - (SH_W+1)'(i_shift);
    assign o_word   = o_dest | (i_hi << i_shift) | (o_lo >> lo_shift);

endmodule

`default_nettype wire

### rtl/equal_subset_partition_check_top.sv
// Top level of the equal subset partition checker.
//
// Input channel (i_in_valid / o_in_ready) takes one word per number of the
// set: i_value and i_last_item, the flag marking the final number.
// A bitmap of reachable subset sums sits in a word memory. Each number
// sweeps all bitmap words from the top down, one read-modify-write per
// cycle, ORing in the bitmap shifted up by the number. A number takes the
// accepting cycle and NUM_WORDS + 2 sweep steps, two of them filling the read
// pipeline. After the last number, one more read fetches the bit for half
// the total and the result word (o_can_split, o_overflow, o_sum_of_set)
// appears on the output channel (o_out_valid / i_out_ready); the input
// reopens in that same cycle.
// The output register holds its word until it is taken; the next set may
// start meanwhile, and its result waits in the block, input blocked, until
// the register is free.
// Reset (i_rst_n low, synchronous) clears the total and the overflow flag and
// marks the bitmap as cleared, as does every result. The memory is not
// swept: the first pass of a set treats every word as cleared and rewrites it.
`default_nettype none

module equal_subset_partition_check_top #(
    parameter int REACH_BITS = 2048,
    parameter int VALUE_BITS = 8,
    parameter int WORD_BITS  = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic                  i_last_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_can_split,
    output logic                       o_overflow,
    output logic [espc_pkg::SUM_W-1:0] o_sum_of_set
);

    localparam int NUM_WORDS = REACH_BITS / WORD_BITS;
    localparam int MAP_BITS  = NUM_WORDS * WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WB_LOG    = $clog2(WORD_BITS);
    localparam int CNT_W     = $clog2(NUM_WORDS + 2);
    localparam int IDX_W     = VALUE_BITS + CNT_W + 1;
    localparam int VX_W      = VALUE_BITS + WB_LOG;
    localparam int T_W       = espc_pkg::SUM_W + VALUE_BITS;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SWEEP  = 2'd1;
    localparam logic [1:0] S_PROBE  = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [CNT_W-1:0]            r_k, n_k;
    logic [VALUE_BITS-1:0]       r_q, n_q;
    logic [WB_LOG-1:0]           r_r, n_r;
    logic                        r_last, n_last;
    logic [espc_pkg::SUM_W-1:0]  r_total, n_total;
    logic                        r_ovf, n_ovf;
    logic                        r_fresh, n_fresh;
    logic [WORD_BITS-1:0]        r_hi, n_hi;
    espc_pkg::t_rd_tag           r_tag_a, n_tag_a;
    espc_pkg::t_rd_tag           r_tag_b, n_tag_b;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_split, n_out_split;
    logic                        r_out_ovf, n_out_ovf;
    logic [espc_pkg::SUM_W-1:0]  r_out_sum, n_out_sum;

    logic                        in_acc;
    logic [VX_W-1:0]             v_ext;
    logic [T_W-1:0]              t_sum;
    logic [CNT_W-1:0]            a_idx;
    logic [IDX_W-1:0]            b_idx;
    logic [espc_pkg::SUM_W-2:0]  half;
    logic                        we;
    logic [ADDR_W-1:0]           waddr;
    logic [ADDR_W-1:0]           raddr_a;
    logic [ADDR_W-1:0]           raddr_b;
    logic [WORD_BITS-1:0]        rdata_a;
    logic [WORD_BITS-1:0]        rdata_b;
    logic [WORD_BITS-1:0]        dest_eff;
    logic [WORD_BITS-1:0]        lo_eff;
    logic [WORD_BITS-1:0]        new_word;
    logic                        out_free;
    logic                        half_bit;

    assign o_in_ready   = (r_state == S_IDLE);
    assign in_acc       = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_can_split  = r_out_split;
    assign o_overflow   = r_out_ovf;
    assign o_sum_of_set = r_out_sum;

    assign v_ext = VX_W'(i_value);
    assign t_sum = T_W'(r_total) + T_W'(i_value);

    // At sweep step k, port A reads the destination word NUM_WORDS-k and
    // port B reads source word NUM_WORDS-1-q-k; the word written at step k
    // is NUM_WORDS-k+1. Writes always land above every later read.
    assign a_idx = CNT_W'(NUM_WORDS) - r_k;
    assign b_idx = IDX_W'(NUM_WORDS - 1) - IDX_W'(r_q) - IDX_W'(r_k);
    assign half  = r_total[espc_pkg::SUM_W-1:1];

    // The probe address is held while the result waits, so the read word
    // stays valid however long the output register is busy.
    always_comb begin
        if (r_state == S_PROBE || r_state == S_RESULT) begin
            raddr_a = ADDR_W'(half >> WB_LOG);
        end else begin
            raddr_a = a_idx[ADDR_W-1:0];
        end
    end

    assign raddr_b = b_idx[ADDR_W-1:0];
    assign we      = (r_state == S_SWEEP) && (r_k >= CNT_W'(2));
    assign waddr   = ADDR_W'(a_idx + CNT_W'(1));

    espc_mem #(
        .DEPTH  (NUM_WORDS),
        .WIDTH  (WORD_BITS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (new_word),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    espc_merge #(
        .WORD_BITS (WORD_BITS),
        .SH_W      (WB_LOG)
    ) u_merge (
        .i_dest_raw (rdata_a),
        .i_dest_tag (r_tag_a),
        .i_lo_raw   (rdata_b),
        .i_lo_tag   (r_tag_b),
        .i_hi       (r_hi),
        .i_shift    (r_r),
        .o_dest     (dest_eff),
        .o_lo       (lo_eff),
        .o_word     (new_word)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign half_bit = dest_eff[half[WB_LOG-1:0]];

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_q         = r_q;
        n_r         = r_r;
        n_last      = r_last;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_fresh     = r_fresh;
        n_hi        = r_hi;
        n_tag_a     = '{outside: 1'b0, fresh: r_fresh, zero_word: (a_idx == '0)};
        n_tag_b     = '{outside: b_idx[IDX_W-1], fresh: r_fresh,
                        zero_word: (b_idx == '0)};
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_split = r_out_split;
        n_out_ovf   = r_out_ovf;
        n_out_sum   = r_out_sum;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_q    = VALUE_BITS'(v_ext >> WB_LOG);
                    n_r    = v_ext[WB_LOG-1:0];
                    n_last = i_last_item;
                    n_k    = '0;
                    if (t_sum > T_W'(espc_pkg::SUM_MAX)) begin
                        n_total = espc_pkg::SUM_MAX;
                        n_ovf   = 1'b1;
                    end else begin
                        n_total = t_sum[espc_pkg::SUM_W-1:0];
                    end
                    if (32'(t_sum) > 32'(MAP_BITS - 1)) begin
                        n_ovf = 1'b1;
                    end
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                // The lower source word of this step is the upper one of the next.
                n_hi = lo_eff;
                n_k  = r_k + CNT_W'(1);
                if (r_k == CNT_W'(NUM_WORDS + 1)) begin
                    n_fresh = 1'b0;
                    n_state = r_last ? S_PROBE : S_IDLE;
                end
            end
            S_PROBE: begin
                n_tag_a = '{outside: 1'b0, fresh: 1'b0, zero_word: 1'b0};
                n_state = S_RESULT;
            end
            S_RESULT: begin
                n_tag_a = r_tag_a;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_split = !r_ovf && !r_total[0] && half_bit;
                    n_out_ovf   = r_ovf;
                    n_out_sum   = r_total;
                    n_total     = '0;
                    n_ovf       = 1'b0;
                    n_fresh     = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_last      <= 1'b0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_last      <= n_last;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q         <= n_q;
        r_r         <= n_r;
        r_hi        <= n_hi;
        r_tag_a     <= n_tag_a;
        r_tag_b     <= n_tag_b;
        r_out_split <= n_out_split;
        r_out_ovf   <= n_out_ovf;
        r_out_sum   <= n_out_sum;
    end

endmodule

`default_nettype wire
